// ===== design/assert_macros.svh =====
// Assertion macros used by the dither top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define EDD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define EDD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/edd_pkg.sv =====
// Shared types, constants and arithmetic for the error diffusion dither.
package edd_pkg;

    localparam int LINE_MAX_DEF = 2048;

    localparam int CH_W  = 8;   // colour channel width
    localparam int ERR_W = 9;   // signed error width
    localparam int QB_W  = 4;   // quant_bits register width
    localparam int LL_W  = 12;  // line_length register width
    localparam int CFG_W = 12;  // widest register
    localparam int IDX_W = 1;

    localparam logic [IDX_W-1:0] REG_QUANT_BITS  = 1'b0;
    localparam logic [IDX_W-1:0] REG_LINE_LENGTH = 1'b1;

    localparam logic [QB_W-1:0] QUANT_BITS_RST  = 4'd1;
    localparam logic [LL_W-1:0] LINE_LENGTH_RST = 12'd2048;

    // Diffusion weights in sixteenths
    localparam logic [2:0] K_DIAG  = 3'd1;
    localparam logic [2:0] K_ABOVE = 3'd5;
    localparam logic [2:0] K_RIGHT = 3'd3;
    localparam logic [2:0] K_LEFT  = 3'd7;

    typedef struct packed {
        logic s1_move;
        logic s2_move;
        logic s1_first;
        logic s1_gt0;
        logic s1_right;
        logic s2_gt0;
    } edd_stage_t;

    // 16p + k*e, negative clips to 0, else >>4 capped at 255
    function automatic logic [CH_W-1:0] diffuse(input logic [CH_W-1:0] p,
                                                input logic [2:0] k,
                                                input logic signed [ERR_W-1:0] e);
        logic signed [13:0] s;
        s = $signed({2'b00, p, 4'b0000}) + $signed({1'b0, k}) * e;
        if (s[13])
            return '0;
        else if (s[13:4] > 10'd255)
            return 8'd255;
        else
            return s[11:4];
    endfunction

    // floor(256 / (2^b - 1)), b already limited to 1..8
    function automatic logic [8:0] quant_step(input logic [QB_W-1:0] b);
        logic [8:0] r;
        case (b)
            4'd1:    r = 9'd256;
            4'd2:    r = 9'd85;
            4'd3:    r = 9'd36;
            4'd4:    r = 9'd17;
            4'd5:    r = 9'd8;
            4'd6:    r = 9'd4;
            4'd7:    r = 9'd2;
            default: r = 9'd1;
        endcase
        return r;
    endfunction

    function automatic logic [CH_W-1:0] quantize(input logic [CH_W-1:0] v,
                                                 input logic [QB_W-1:0] b);
        logic [2:0]      sh;
        logic [CH_W-1:0] pick;
        logic [16:0]     q;
        sh   = 3'(4'd8 - b);
        pick = (v != '0) ? ((v - 8'd1) >> sh) : '0;
        q    = 17'(pick) * 17'(quant_step(b));
        return (q > 17'd255) ? 8'd255 : q[7:0];
    endfunction

endpackage

// ===== design/edd_channel.sv =====
// One colour channel: neighbour diffusion, left diffusion, quantizer and error.
module edd_channel
    import edd_pkg::*;
(
    input  logic                    clk,
    input  edd_stage_t              stage,
    input  logic [CH_W-1:0]         pixel,
    input  logic signed [ERR_W-1:0] above,
    input  logic signed [ERR_W-1:0] right,
    input  logic [QB_W-1:0]         bits,
    output logic [CH_W-1:0]         level,
    output logic signed [ERR_W-1:0] err
);

    logic [CH_W-1:0]         v1_reg;
    logic [CH_W-1:0]         v1_next;
    logic signed [ERR_W-1:0] diag_reg;
    logic signed [ERR_W-1:0] left_reg;
    logic [CH_W-1:0]         v2;
    logic [CH_W-1:0]         a_val;
    logic [CH_W-1:0]         b_val;

    // stage 1: errors from the line above
    always_comb
    begin
        a_val = stage.s1_gt0 ? diffuse(pixel, K_DIAG, diag_reg) : pixel;
        b_val = diffuse(a_val, K_ABOVE, above);
        if (stage.s1_first)
            v1_next = pixel;
        else if (stage.s1_right)
            v1_next = diffuse(b_val, K_RIGHT, right);
        else
            v1_next = b_val;
    end

    // stage 2: left error, closes the pixel-to-pixel loop
    assign v2    = stage.s2_gt0 ? diffuse(v1_reg, K_LEFT, left_reg) : v1_reg;
    assign level = quantize(v2, bits);
    assign err   = $signed({1'b0, v2}) - $signed({1'b0, level});

    always_ff @(posedge clk)
    begin
        if (stage.s1_move)
        begin
            v1_reg <= v1_next;
            if (!stage.s1_first)
                diag_reg <= above;
        end
        if (stage.s2_move)
            left_reg <= err;
    end

endmodule

// ===== design/error_diffusion_dither.sv =====
// Top level of the error diffusion dither: handshake, line position, line store.
//
//  channel | dir | payload
//  s_axis  | in  | tdata: red, green, blue; tuser: frame_start
//  m_axis  | out | tdata: out_red, out_green, out_blue
//  cfg     | in  | cfg_index 0 quant_bits, 1 line_length; write on cfg_we
//
// One pixel per clock while nothing stalls; a pixel passes through stage 1, stage 2
// and the output register. With length 1 past the first line, and length 2 at each
// later line start, the interlock holds a pixel while the entry it reads is pending.
// The 7/16 left error, quantizer and error subtract loop through left_reg alone.
// Reset (rst_n, async) restores config defaults and control, not the line store.
// A full output register with tready low holds the pipeline; empty stages still fill.
`include "assert_macros.svh"

module error_diffusion_dither
    import edd_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic               s_axis_tuser,   // frame_start
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [23:0]        m_axis_tdata,   // out_red, out_green, out_blue
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int AW   = $clog2(LINE_MAX);
    localparam int LW   = AW + 1;
    localparam int CW   = (LW > LL_W) ? LW : LL_W;
    localparam int ME_W = 3 * ERR_W;

    typedef struct packed {
        logic [AW-1:0] pos;
        logic [AW-1:0] nxt;   // pos + 1, also the above-right address
        logic          first;
        logic          gt0;
        logic          right;
        logic          wrap;
    } pos_info_t;

    // config
    logic [QB_W-1:0] quant_bits_reg;
    logic [LL_W-1:0] line_length_reg;
    logic [QB_W-1:0] bits_eff;
    logic [LW-1:0]   len_eff;
    logic [CW-1:0]   len_ext;

    // position
    logic [AW-1:0] pos_reg;
    logic          first_reg;
    pos_info_t     acc;
    pos_info_t     pre;

    // pipeline
    logic             s1_valid_reg;
    logic [AW-1:0]    s1_pos_reg;
    logic             s1_first_reg;
    logic             s1_gt0_reg;
    logic             s1_right_reg;
    logic [23:0]      s1_pix_reg;
    logic             s2_valid_reg;
    logic [AW-1:0]    s2_pos_reg;
    logic             s2_gt0_reg;
    logic             o_valid_reg;
    logic [23:0]      o_data_reg;

    logic out_free, s2_move, s2_free, s1_move, s1_free, accept, hazard;
    logic conf_pos, conf_nxt;
    edd_stage_t stage;

    // line store
    logic [ME_W-1:0] mem [LINE_MAX];
    logic [ME_W-1:0] rd_above_reg;
    logic [ME_W-1:0] rd_right_reg;
    logic [ME_W-1:0] err_all;
    logic [23:0]     level_all;

    function automatic pos_info_t pos_calc(input logic fs, input logic [AW-1:0] p,
                                           input logic f, input logic [LW-1:0] len);
        pos_info_t     r;
        logic [LW-1:0] pe;
        logic [LW-1:0] nx;
        pe      = fs ? '0 : {1'b0, p};
        r.first = fs | f;
        if (pe >= len)
        begin
            pe      = '0;
            r.first = 1'b0;
        end
        nx      = pe + LW'(1);
        r.pos   = pe[AW-1:0];
        r.nxt   = nx[AW-1:0];
        r.gt0   = (pe != '0);
        r.right = (nx < len);
        r.wrap  = !(nx < len);
        return r;
    endfunction

    // effective settings: out-of-range values fold to the nearest legal one
    assign len_ext  = CW'(line_length_reg);
    assign bits_eff = (quant_bits_reg == '0) ? 4'd1 :
                      (quant_bits_reg > 4'd8) ? 4'd8 : quant_bits_reg;
    assign len_eff  = (len_ext == '0) ? LW'(1) :
                      (len_ext > CW'(LINE_MAX)) ? LW'(LINE_MAX) : LW'(len_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_bits_reg  <= QUANT_BITS_RST;
            line_length_reg <= LINE_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUANT_BITS:  quant_bits_reg  <= cfg_data[QB_W-1:0];
                REG_LINE_LENGTH: line_length_reg <= cfg_data[LL_W-1:0];
                default: ;
            endcase
        end
    end

    // acc: the actual request; pre: the same without frame start, for the interlock
    assign acc = pos_calc(s_axis_tuser, pos_reg, first_reg, len_eff);
    assign pre = pos_calc(1'b0, pos_reg, first_reg, len_eff);

    assign out_free = !o_valid_reg || m_axis_tready;
    assign s2_move  = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    // read-after-write interlock: an in-flight pixel that has not yet written
    // the entry this request needs. A write in the same cycle is bypassed.
    assign conf_pos = (s1_valid_reg && s1_pos_reg == pre.pos)
                   || (s2_valid_reg && !s2_move && s2_pos_reg == pre.pos);
    assign conf_nxt = (s1_valid_reg && s1_pos_reg == pre.nxt)
                   || (s2_valid_reg && !s2_move && s2_pos_reg == pre.nxt);
    assign hazard   = !pre.first && (conf_pos || (pre.right && conf_nxt));

    assign s_axis_tready = s1_free && !hazard;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            first_reg    <= 1'b1;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg   <= acc.wrap ? '0 : acc.nxt;
                first_reg <= acc.wrap ? 1'b0 : acc.first;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                s2_valid_reg <= 1'b1;
            else if (s2_move)
                s2_valid_reg <= 1'b0;
            if (s2_move)
                o_valid_reg <= 1'b1;
            else if (m_axis_tready)
                o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= acc.pos;
            s1_first_reg <= acc.first;
            s1_gt0_reg   <= acc.gt0;
            s1_right_reg <= acc.right;
            s1_pix_reg   <= s_axis_tdata;
        end
        if (s1_move)
        begin
            s2_pos_reg <= s1_pos_reg;
            s2_gt0_reg <= s1_gt0_reg;
        end
        if (s2_move)
            o_data_reg <= level_all;
    end

    // line store: errors of the line above, written back as each pixel leaves
    always_ff @(posedge clk)
    begin
        if (s2_move)
            mem[s2_pos_reg] <= err_all;
        if (accept)
        begin
            rd_above_reg <= (s2_move && s2_pos_reg == acc.pos) ? err_all : mem[acc.pos];
            rd_right_reg <= (s2_move && s2_pos_reg == acc.nxt) ? err_all : mem[acc.nxt];
        end
    end

    assign stage.s1_move  = s1_move;
    assign stage.s2_move  = s2_move;
    assign stage.s1_first = s1_first_reg;
    assign stage.s1_gt0   = s1_gt0_reg;
    assign stage.s1_right = s1_right_reg;
    assign stage.s2_gt0   = s2_gt0_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        edd_channel u_ch (
            .clk   (clk),
            .stage (stage),
            .pixel (s1_pix_reg[c*CH_W +: CH_W]),
            .above ($signed(rd_above_reg[c*ERR_W +: ERR_W])),
            .right ($signed(rd_right_reg[c*ERR_W +: ERR_W])),
            .bits  (bits_eff),
            .level (level_all[c*CH_W +: CH_W]),
            .err   (err_all[c*ERR_W +: ERR_W])
        );
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;

    `EDD_ASSERT_IMP(a_no_stale_read, clk, rst_n, accept && !acc.first && s1_valid_reg, (s1_pos_reg != acc.pos) && !(acc.right && s1_pos_reg == acc.nxt), "request read a line-store entry still pending")
    `EDD_ASSERT_IMP(a_out_hold, clk, rst_n, o_valid_reg && !m_axis_tready, !s2_move, "result overwritten before taken")
    `EDD_ASSERT_NXT(a_s2_to_out, clk, rst_n, s2_move, o_valid_reg, "pixel left stage 2 without a result")

endmodule
